>>> rtl/rhp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rhp_pkg
// Shared types and constants for the RTP header parser: transfer payloads,
// the per-packet snapshot and the length arithmetic widths.
// ----------------------------------------------------------------------------
package rhp_pkg;

  // Width of the byte counter; packets longer than 2^LENGTH_BITS - 1 are flagged
  localparam int LENGTH_BITS = 16;
  localparam logic [LENGTH_BITS-1:0] MAX_LEN = {LENGTH_BITS{1'b1}};

  // Width that holds size, extension length and padding sums without overflow
  localparam int CALC_W = ((LENGTH_BITS > 19) ? LENGTH_BITS : 19) + 1;

  localparam logic [1:0] RTP_VERSION = 2'd2;
  localparam int         FIXED_HDR   = 12;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic        packet_ok;
    logic [6:0]  payload_type;
    logic        marker_bit;
    logic [15:0] sequence_number;
    logic [31:0] time_stamp;
    logic [31:0] source_id;
    logic        extension_present;
    logic [15:0] extension_offset;
    logic [15:0] extension_bytes;
    logic [15:0] payload_offset;
    logic [15:0] payload_bytes;
    logic [7:0]  padding_bytes;
  } result_t;

  // Captured state of one packet as it stands after its final byte
  typedef struct packed {
    logic                   too_long;
    logic [LENGTH_BITS-1:0] size;
    logic [7:0]             first_hdr;
    logic [7:0]             second_hdr;
    logic [15:0]            seq;
    logic [31:0]            stamp;
    logic [31:0]            source;
    logic [15:0]            word_count;
    logic [7:0]             final_byte;
  } snap_t;

endpackage
`default_nettype wire

>>> rtl/rhp_capture.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rhp_capture
// Byte counter and header capture. Presents the packet snapshot as it will
// stand once the current byte is taken, and clears after each final byte.
// ----------------------------------------------------------------------------
module rhp_capture
  import rhp_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  accept,
  input  item_t item,
  output snap_t snap
);

  logic [LENGTH_BITS-1:0] byte_position, byte_position_next;
  logic                   too_long_flag, too_long_flag_next;
  logic [7:0]             first_header_byte, first_header_byte_next;
  logic [7:0]             second_header_byte, second_header_byte_next;
  logic [15:0]            seq_capture, seq_capture_next;
  logic [31:0]            stamp_capture, stamp_capture_next;
  logic [31:0]            source_capture, source_capture_next;
  logic [15:0]            ext_word_count, ext_word_count_next;
  logic [LENGTH_BITS-1:0] ext_at, wc_hi_at, wc_lo_at;

  // Locate the extension word count: 12 + 4*CC, then bytes 2 and 3 of it
  assign ext_at   = LENGTH_BITS'(FIXED_HDR) +
                    {{(LENGTH_BITS-6){1'b0}}, first_header_byte[3:0], 2'b00};
  assign wc_hi_at = ext_at + LENGTH_BITS'(2);
  assign wc_lo_at = ext_at + LENGTH_BITS'(3);

  // Work out the state after this byte
  always_comb begin
    byte_position_next      = byte_position;
    too_long_flag_next      = too_long_flag;
    first_header_byte_next  = first_header_byte;
    second_header_byte_next = second_header_byte;
    seq_capture_next        = seq_capture;
    stamp_capture_next      = stamp_capture;
    source_capture_next     = source_capture;
    ext_word_count_next     = ext_word_count;
    if (!too_long_flag) begin
      if (byte_position == LENGTH_BITS'(0)) begin
        first_header_byte_next = item.data_byte;
      end else if (byte_position == LENGTH_BITS'(1)) begin
        second_header_byte_next = item.data_byte;
      end else if (byte_position <= LENGTH_BITS'(3)) begin
        seq_capture_next = {seq_capture[7:0], item.data_byte};
      end else if (byte_position <= LENGTH_BITS'(7)) begin
        stamp_capture_next = {stamp_capture[23:0], item.data_byte};
      end else if (byte_position <= LENGTH_BITS'(11)) begin
        source_capture_next = {source_capture[23:0], item.data_byte};
      end
      if (byte_position >= LENGTH_BITS'(FIXED_HDR) &&
          (byte_position == wc_hi_at || byte_position == wc_lo_at)) begin
        ext_word_count_next = {ext_word_count[7:0], item.data_byte};
      end
    end
    // Saturate the counter and flag an overlong packet
    if (byte_position == MAX_LEN) begin
      too_long_flag_next = 1'b1;
    end else begin
      byte_position_next = byte_position + LENGTH_BITS'(1);
    end
  end

  assign snap.too_long   = too_long_flag_next;
  assign snap.size       = byte_position_next;
  assign snap.first_hdr  = first_header_byte_next;
  assign snap.second_hdr = second_header_byte_next;
  assign snap.seq        = seq_capture_next;
  assign snap.stamp      = stamp_capture_next;
  assign snap.source     = source_capture_next;
  assign snap.word_count = ext_word_count_next;
  assign snap.final_byte = item.data_byte;

  // Advance on each transfer; clear after the final byte
  always_ff @(posedge clk) begin
    if (rst || (accept && item.last_byte)) begin
      byte_position      <= '0;
      too_long_flag      <= 1'b0;
      first_header_byte  <= '0;
      second_header_byte <= '0;
      seq_capture        <= '0;
      stamp_capture      <= '0;
      source_capture     <= '0;
      ext_word_count     <= '0;
    end else if (accept) begin
      byte_position      <= byte_position_next;
      too_long_flag      <= too_long_flag_next;
      first_header_byte  <= first_header_byte_next;
      second_header_byte <= second_header_byte_next;
      seq_capture        <= seq_capture_next;
      stamp_capture      <= stamp_capture_next;
      source_capture     <= source_capture_next;
      ext_word_count     <= ext_word_count_next;
    end
  end

endmodule
`default_nettype wire

>>> rtl/rhp_verdict.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rhp_verdict
// Length and version checks on a packet snapshot, and the extension and
// payload offsets and lengths that follow from them.
// ----------------------------------------------------------------------------
module rhp_verdict
  import rhp_pkg::*;
(
  input  snap_t   snap,
  output result_t result
);

  logic              xbit, pbit, base_ok, ext_fail, pad_fail, ok;
  logic [CALC_W-1:0] size_w, ext_off, ext_len, min_ext, pad, min_pad, pay_len;
  logic [16:0]       words_plus_one;

  assign xbit = snap.first_hdr[4];
  assign pbit = snap.first_hdr[5];

  assign size_w  = CALC_W'(snap.size);
  assign ext_off = CALC_W'(FIXED_HDR) + CALC_W'({snap.first_hdr[3:0], 2'b00});

  // Basic header checks
  assign base_ok = !snap.too_long && (size_w >= CALC_W'(FIXED_HDR)) &&
                   (snap.first_hdr[7:6] == RTP_VERSION);

  // Extension header must fit
  assign words_plus_one = {1'b0, snap.word_count} + 17'd1;
  assign ext_fail = xbit && (size_w < ext_off + CALC_W'(4));
  assign ext_len  = xbit ? CALC_W'({words_plus_one, 2'b00}) : '0;
  assign min_ext  = ext_off + ext_len;

  // Padding must leave room past the header and cover its own length
  assign pad_fail = pbit && (size_w <= min_ext);
  assign pad      = !pbit ? '0 :
                    (snap.final_byte == 8'd0) ? CALC_W'(1) : CALC_W'(snap.final_byte);
  assign min_pad  = min_ext + pad;

  assign ok      = base_ok && !ext_fail && !pad_fail && (size_w >= min_pad);
  assign pay_len = size_w - min_pad;

  // Assemble the result; lengths read zero on a failed packet
  always_comb begin
    result.packet_ok         = ok;
    result.payload_type      = snap.second_hdr[6:0];
    result.marker_bit        = snap.second_hdr[7];
    result.sequence_number   = snap.seq;
    result.time_stamp        = snap.stamp;
    result.source_id         = snap.source;
    result.extension_present = xbit;
    result.extension_offset  = (ok && xbit) ? ext_off[15:0] : 16'd0;
    result.extension_bytes   = ok ? ext_len[15:0] : 16'd0;
    result.payload_offset    = ok ? min_ext[15:0] : 16'd0;
    result.payload_bytes     = ok ? pay_len[15:0] : 16'd0;
    result.padding_bytes     = ok ? pad[7:0] : 8'd0;
  end

endmodule
`default_nettype wire

>>> rtl/rtp_header_parse_validate.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rtp_header_parse_validate
// RTP fixed header parser and length validator, one byte per transfer.
// ----------------------------------------------------------------------------
// Accepts one packet byte per clock cycle while input is not stalled, with no
// gap needed between packets. Each byte updates the byte counter and header
// capture in the cycle it is taken; the final byte loads a snapshot register,
// which drains through the length checks into the result register once that
// register is free, and the result is offered from there. The two registers
// form a short pipeline, so bytes keep flowing while a result waits to be
// taken; input stalls only when both registers hold undelivered results.
// ----------------------------------------------------------------------------
module rtp_header_parse_validate
  import rhp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_ready,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  logic    accept, snap_valid, snap_move, result_load;
  snap_t   snap_next, snap_q;
  result_t verdict;

  rhp_capture u_capture (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (item),
    .snap   (snap_next)
  );

  rhp_verdict u_verdict (
    .snap   (snap_q),
    .result (verdict)
  );

  // Handshake: snapshot drains into the result register when that is free
  assign result_load = !result_valid || result_ready;
  assign snap_move   = snap_valid && result_load;
  assign item_ready  = !snap_valid || snap_move;
  assign accept      = item_valid && item_ready;

  // Hold the snapshot of a finished packet
  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
    end else if (accept && item.last_byte) begin
      snap_valid <= 1'b1;
    end else if (snap_move) begin
      snap_valid <= 1'b0;
    end
    if (accept && item.last_byte) begin
      snap_q <= snap_next;
    end
  end

  // Register the verdict for transfer out
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (result_load) begin
      result_valid <= snap_valid;
    end
    if (snap_move) begin
      result <= verdict;
    end
  end

  // A final byte always leaves a snapshot behind
  a_last_loads_snap: assert property (@(posedge clk) disable iff (rst)
    accept && item.last_byte |=> snap_valid)
    else $error("final byte transfer did not load snapshot");

  // A failed packet carries no lengths
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.packet_ok |->
      result.payload_bytes == 16'd0 && result.payload_offset == 16'd0 &&
      result.padding_bytes == 8'd0 && result.extension_bytes == 16'd0)
    else $error("failed packet reports nonzero lengths");

  // A good packet's payload starts past the fixed header
  a_ok_offset: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.packet_ok |-> result.payload_offset >= 16'd12)
    else $error("payload offset inside fixed header");

  // No extension means no extension length
  a_no_ext: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.extension_present |->
      result.extension_bytes == 16'd0 && result.extension_offset == 16'd0)
    else $error("extension length without X bit");

  // A snapshot waiting on a full result register blocks input
  a_stall: assert property (@(posedge clk) disable iff (rst)
    snap_valid && result_valid && !result_ready |-> !item_ready)
    else $error("input taken with both stages full");

endmodule
`default_nettype wire

>>> bench/tb_rtp_header_parse_validate.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rtp_header_parse_validate
// Self-checking bench for the RTP header parser and length validator.
// ----------------------------------------------------------------------------
// Streams RTP packets into the block one byte per transfer and predicts the
// verdict of each packet from the accepted bytes alone. Every verdict taken
// from the block is compared field by field with the oldest prediction.
// A short directed run covers the header extremes, short, overlong and
// maximum-length packets, and the extension and padding boundaries. Random
// packets follow, mostly well formed with random content, the rest broken
// or noise. Sender gaps and receiver stalls vary from phase to phase.
// ----------------------------------------------------------------------------
module tb_rtp_header_parse_validate;
  import rhp_pkg::*;

  localparam int HALF_PERIOD = 5;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int TAIL_CYCLES = 8;

  typedef enum {
    FLAW_NONE, FLAW_VERSION, FLAW_TRUNCATED, FLAW_EXT_OVERRUN, FLAW_PAD_OVERRUN, FLAW_NOISE
  } flaw_t;

  // Predicts one verdict per packet and holds those still to be delivered
  class rtp_verdict_board;
    result_t                pending[$];
    int                     mismatches;
    logic [LENGTH_BITS-1:0] byte_count;
    bit                     overlong;
    logic [7:0]             hdr0;
    logic [7:0]             hdr1;
    logic [15:0]            seq;
    logic [31:0]            stamp;
    logic [31:0]            ssrc;
    logic [15:0]            word_count;

    function new();
      mismatches = 0;
      clear_packet();
    endfunction

    function void clear_packet();
      byte_count = '0;
      overlong   = 1'b0;
      hdr0       = '0;
      hdr1       = '0;
      seq        = '0;
      stamp      = '0;
      ssrc       = '0;
      word_count = '0;
    endfunction

    function result_t predict_verdict(logic [7:0] final_b);
      result_t r;
      int      size;
      int      ext_off;
      int      ext_len;
      int      min_len;
      int      pad;
      bit      ok;
      size    = int'(byte_count);
      ext_off = FIXED_HDR + 4 * int'(hdr0[3:0]);
      ext_len = 0;
      pad     = 0;
      ok      = !overlong && size >= FIXED_HDR && hdr0[7:6] == RTP_VERSION;
      min_len = ext_off;
      // extension header must fit before its length counts
      if (ok && hdr0[4]) begin
        if (size < min_len + 4) ok = 1'b0;
        else begin
          ext_len = 4 * (int'(word_count) + 1);
          min_len += ext_len;
        end
      end
      // padding needs room past the header; a zero count still means one byte
      if (ok && hdr0[5]) begin
        if (size <= min_len) ok = 1'b0;
        else begin
          pad = (final_b == 8'd0) ? 1 : int'(final_b);
          min_len += pad;
        end
      end
      if (ok && size < min_len) ok = 1'b0;

      r = '0;
      r.packet_ok         = ok;
      r.payload_type      = hdr1[6:0];
      r.marker_bit        = hdr1[7];
      r.sequence_number   = seq;
      r.time_stamp        = stamp;
      r.source_id         = ssrc;
      r.extension_present = hdr0[4];
      if (ok) begin
        if (hdr0[4]) r.extension_offset = 16'(ext_off);
        r.extension_bytes = 16'(ext_len);
        r.payload_offset  = 16'(ext_off + ext_len);
        r.payload_bytes   = 16'(size - ext_off - ext_len - pad);
        r.padding_bytes   = 8'(pad);
      end
      return r;
    endfunction

    // Note one accepted byte; the final byte yields a prediction
    function void take_byte(item_t it);
      int pos;
      int ext_at;
      pos = int'(byte_count);
      if (!overlong) begin
        if (pos == 0) hdr0 = it.data_byte;
        else if (pos == 1) hdr1 = it.data_byte;
        else if (pos <= 3) seq = {seq[7:0], it.data_byte};
        else if (pos <= 7) stamp = {stamp[23:0], it.data_byte};
        else if (pos <= 11) ssrc = {ssrc[23:0], it.data_byte};
        if (pos >= FIXED_HDR) begin
          ext_at = FIXED_HDR + 4 * int'(hdr0[3:0]);
          if (pos == ext_at + 2 || pos == ext_at + 3)
            word_count = {word_count[7:0], it.data_byte};
        end
      end
      if (byte_count == MAX_LEN) overlong = 1'b1;
      else byte_count = byte_count + 1'b1;
      if (it.last_byte) begin
        pending.push_back(predict_verdict(it.data_byte));
        clear_packet();
      end
    endfunction

    function void check_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
        mismatches++;
      end
    endfunction

    // Compare one delivered verdict with the oldest prediction
    function void check_verdict(result_t got);
      result_t want;
      if (pending.size() == 0) begin
        $error("verdict delivered with none outstanding");
        mismatches++;
        return;
      end
      want = pending.pop_front();
      check_field("packet_ok", want.packet_ok, got.packet_ok);
      check_field("payload_type", want.payload_type, got.payload_type);
      check_field("marker_bit", want.marker_bit, got.marker_bit);
      check_field("sequence_number", want.sequence_number, got.sequence_number);
      check_field("time_stamp", want.time_stamp, got.time_stamp);
      check_field("source_id", want.source_id, got.source_id);
      check_field("extension_present", want.extension_present, got.extension_present);
      check_field("extension_offset", want.extension_offset, got.extension_offset);
      check_field("extension_bytes", want.extension_bytes, got.extension_bytes);
      check_field("payload_offset", want.payload_offset, got.payload_offset);
      check_field("payload_bytes", want.payload_bytes, got.payload_bytes);
      check_field("padding_bytes", want.padding_bytes, got.padding_bytes);
    endfunction
  endclass

  logic    clk;
  logic    rst;
  logic    item_valid;
  logic    item_ready;
  item_t   item;
  logic    result_valid;
  logic    result_ready;
  result_t result;

  rtp_verdict_board board = new();
  logic [7:0]       packet_bytes[$];
  int               send_idle_pct;
  int               stall_pct;
  int               cycle_count;

  rtp_header_parse_validate dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  // Known values on every input from time zero
  initial begin
    clk           = 1'b0;
    rst           = 1'b1;
    item_valid    = 1'b0;
    item          = '0;
    result_ready  = 1'b0;
    send_idle_pct = 0;
    stall_pct     = 0;
  end

  always #HALF_PERIOD clk = ~clk;

  // Note every byte transfer
  always @(posedge clk) begin
    if (!rst && item_valid && item_ready) board.take_byte(item);
  end

  // Stall the result side at random and check every result transfer
  always @(posedge clk) begin
    result_ready <= ($urandom_range(99) >= stall_pct);
    if (!rst && result_valid && result_ready) board.check_verdict(result);
  end

  // Abort a hung run
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  // Offer one byte, with random gaps before it, and hold it until transfer
  task automatic send_byte(input logic [7:0] data, input logic last);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= '{data_byte: data, last_byte: last};
    do @(posedge clk); while (!item_ready);
  endtask

  task automatic send_packet();
    foreach (packet_bytes[i]) send_byte(packet_bytes[i], i == packet_bytes.size() - 1);
  endtask

  // Drop valid and hold off until every verdict has been delivered
  task automatic settle();
    item_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  function automatic void fill_bytes(logic [7:0] first, logic [7:0] rest, int count);
    packet_bytes.delete();
    packet_bytes.push_back(first);
    repeat (count - 1) packet_bytes.push_back(rest);
  endfunction

  // Lay out a packet: fixed header, CSRC list, extension, payload, padding
  function automatic void build_rtp(logic [1:0] ver, bit pad_on, bit ext_on, int cc,
                                    logic [15:0] wc, int words, int pay, int padn,
                                    logic [7:0] pad_tail);
    packet_bytes.delete();
    packet_bytes.push_back({ver, pad_on, ext_on, 4'(cc)});
    repeat (11 + 4 * cc) packet_bytes.push_back(8'($urandom));
    if (ext_on) begin
      repeat (2) packet_bytes.push_back(8'($urandom));
      packet_bytes.push_back(wc[15:8]);
      packet_bytes.push_back(wc[7:0]);
      repeat (4 * words) packet_bytes.push_back(8'($urandom));
    end
    repeat (pay) packet_bytes.push_back(8'($urandom));
    if (padn > 0) begin
      repeat (padn - 1) packet_bytes.push_back(8'($urandom));
      packet_bytes.push_back(pad_tail);
    end
  endfunction

  // Mostly well-formed packets with random content, the rest broken
  function automatic void make_random_packet();
    flaw_t      flaw;
    logic [1:0] ver;
    bit         p;
    bit         x;
    int         cc;
    int         wc;
    int         words;
    int         pay;
    int         padn;
    logic [7:0] tail;
    flaw  = ($urandom_range(99) < 80) ? FLAW_NONE : flaw_t'($urandom_range(1, 5));
    ver   = RTP_VERSION;
    p     = 1'($urandom_range(1));
    x     = 1'($urandom_range(1));
    cc    = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(3);
    wc    = $urandom_range(3);
    words = wc;
    pay   = $urandom_range(12);
    padn  = p ? $urandom_range(1, 6) : 0;
    tail  = 8'(padn);
    if (p && $urandom_range(5) == 0) begin
      padn = 1;
      tail = 8'd0;
    end
    case (flaw)
      FLAW_VERSION: begin
        ver = 2'($urandom_range(2));
        if (ver == RTP_VERSION) ver = 2'd3;
      end
      FLAW_EXT_OVERRUN: begin
        x     = 1'b1;
        wc    = $urandom_range(65535);
        words = $urandom_range(3);
      end
      FLAW_PAD_OVERRUN: begin
        p    = 1'b1;
        padn = $urandom_range(1, 4);
        tail = 8'($urandom_range(padn + 1, 255));
      end
      default: ;
    endcase
    build_rtp(ver, p, x, cc, 16'(wc), words, pay, padn, tail);
    if (flaw == FLAW_TRUNCATED) begin
      int keep;
      keep = $urandom_range(1, packet_bytes.size() - 1);
      while (packet_bytes.size() > keep) void'(packet_bytes.pop_back());
    end
    if (flaw == FLAW_NOISE) begin
      packet_bytes.delete();
      repeat ($urandom_range(1, 40)) packet_bytes.push_back(8'($urandom));
    end
  endfunction

  initial begin
    int phase_bytes;
    int phase_pkts;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: short packets, header extremes, bad versions
    fill_bytes(8'h80, 8'h00, 1);   send_packet();
    fill_bytes(8'h80, 8'h5A, 11);  send_packet();
    fill_bytes(8'h80, 8'hFF, 12);  send_packet();
    fill_bytes(8'h80, 8'h00, 12);  send_packet();
    fill_bytes(8'h00, 8'hA5, 12);  send_packet();
    fill_bytes(8'h40, 8'h3C, 12);  send_packet();
    fill_bytes(8'hFF, 8'hFF, 20);  send_packet();
    // Extension boundaries: header cut short, exact fit, count overrun
    fill_bytes(8'h90, 8'h00, 15);  send_packet();
    fill_bytes(8'h90, 8'h00, 16);  send_packet();
    fill_bytes(8'h90, 8'h01, 16);  send_packet();
    // Padding boundaries: no room, zero count as one byte, count overrun
    fill_bytes(8'hA0, 8'h00, 12);  send_packet();
    fill_bytes(8'hA0, 8'h00, 13);  send_packet();
    fill_bytes(8'hA0, 8'h02, 13);  send_packet();
    // Full CSRC list with extension and padding
    build_rtp(RTP_VERSION, 1'b1, 1'b1, 15, 16'd2, 2, 5, 3, 8'd3);
    send_packet();
    // Longest packet the counter allows, with the largest padding
    build_rtp(RTP_VERSION, 1'b1, 1'b1, 2, 16'd3, 3, 65535 - 36 - 255, 255, 8'd255);
    send_packet();
    // Overlong packet, then an ordinary one to show the restart
    build_rtp(RTP_VERSION, 1'b0, 1'b0, 0, 16'd0, 0, 65539 - FIXED_HDR, 0, 8'd0);
    send_packet();
    build_rtp(RTP_VERSION, 1'b0, 1'b1, 1, 16'd1, 1, 4, 0, 8'd0);
    send_packet();
    settle();

    // Random packets under each idling mix
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 82; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 82; end
        default: begin send_idle_pct = 15; stall_pct = 15; end
      endcase
      phase_bytes = 0;
      phase_pkts  = 0;
      while (phase_bytes < 215 || phase_pkts < 15) begin
        make_random_packet();
        phase_bytes += packet_bytes.size();
        send_packet();
        phase_pkts++;
      end
      settle();
    end

    // Let any late or stray verdict show up
    repeat (TAIL_CYCLES) @(posedge clk);
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
